FILE: hw/rtl/pic_pkg.sv
// Shared constants, types and codes of the platform interrupt controller.
package pic_pkg;

  localparam int CONTEXTS = 2;
  localparam int NSRC     = 32;
  localparam int SRC_W    = 5;
  localparam int DATA_W   = 32;
  localparam int OFF_W    = 26;
  localparam int CTX_W    = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam int IRQ_N    = (CONTEXTS < 2) ? CONTEXTS : 2;
  localparam int IRQ_W    = 2;

  localparam logic [OFF_W-1:0] PRIO_END     = 26'h000_1000;
  localparam logic [OFF_W-1:0] PEND_BASE    = 26'h000_1000;
  localparam logic [OFF_W-1:0] PEND_END     = 26'h000_1080;
  localparam logic [OFF_W-1:0] ENAB_BASE    = 26'h000_2000;
  localparam logic [OFF_W-1:0] ENAB_END     = OFF_W'(32'h0000_2000 + CONTEXTS * 32'h80);
  localparam logic [OFF_W-1:0] CTX_REG_BASE = 26'h020_0000;
  localparam logic [OFF_W-1:0] CTX_END      = OFF_W'(32'h0020_0000 + CONTEXTS * 32'h1000);

  localparam logic [11:0] REG_THRESH = 12'h000;
  localparam logic [11:0] REG_CLAIM  = 12'h004;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LEVEL = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLAIM,
    ST_IRQ0,
    ST_IRQ1,
    ST_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              vld;
    logic [DATA_W-1:0] prio;
    logic [SRC_W-1:0]  id;
  } node_t;

  typedef struct packed {
    logic irq;
    logic ctx;
  } tag_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic tree_go;
    logic sel_irq;
    logic irq_ctx;
    logic claim_apply;
  } cmd_t;

  typedef struct packed {
    logic is_claim;
    logic res_vld;
    logic res_irq;
    logic res_last;
  } sts_t;

endpackage

FILE: hw/rtl/platform_interrupt_controller.sv
// RISC-V style interrupt controller: 31 sources, CONTEXTS targets.
//
// Usage: drive opcode_i, bus_offset_i, write_data_i, source_id_i and
// source_level_i and raise start; the beat is taken at the edge where start
// is high and busy is low. Opcode read returns a register in read_data_o,
// write updates the register map, level change sets or clears a pending bit.
// Exactly one result beat follows each input beat: strobe is high for one
// cycle with read_data_o (zero unless a read) and context_irq_o, the line of
// contexts 0 and 1 after the beat took effect. The receiver cannot stall.
// The sequencer holds busy high and takes no new beat before the result
// strobe of the current one; each beat runs the five-stage registered
// priority tree once for a claim and once for each visible context line.
// Reset clears all priorities, pending bits, enables, thresholds, claims
// and the context lines, and returns the sequencer to idle.
module platform_interrupt_controller import pic_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              strobe,
  input  logic [1:0]        opcode_i,
  input  logic [OFF_W-1:0]  bus_offset_i,
  input  logic [DATA_W-1:0] write_data_i,
  input  logic [SRC_W-1:0]  source_id_i,
  input  logic              source_level_i,
  output logic [DATA_W-1:0] read_data_o,
  output logic [IRQ_W-1:0]  context_irq_o
);

  cmd_t cmd;
  sts_t sts;

  pic_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  pic_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .opcode_i       (opcode_i),
    .bus_offset_i   (bus_offset_i),
    .write_data_i   (write_data_i),
    .source_id_i    (source_id_i),
    .source_level_i (source_level_i),
    .read_data_o    (read_data_o),
    .context_irq_o  (context_irq_o)
  );

endmodule

FILE: hw/rtl/pic_tree.sv
// Registered max-priority tree over all sources, lowest id wins ties.
module pic_tree import pic_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  tag_t             tag_i,
  input  node_t            leaf_i [NSRC],
  output logic             vld_o,
  output tag_t             tag_o,
  output logic [SRC_W-1:0] id_o
);

  function automatic node_t pick(node_t a, node_t b);
    node_t r;
    r = a;
    if (b.vld && (!a.vld || (b.prio > a.prio))) begin
      r = b;
    end
    return r;
  endfunction

  node_t l1_q [NSRC/2];
  node_t l2_q [NSRC/4];
  node_t l3_q [NSRC/8];
  node_t l4_q [NSRC/16];
  node_t res_q;
  logic [4:0] vld_q;
  tag_t       tag_q [5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], go_i};
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q[0] <= tag_i;
    for (int s = 1; s < 5; s++) begin
      tag_q[s] <= tag_q[s-1];
    end
    for (int i = 0; i < NSRC/2; i++) begin
      l1_q[i] <= pick(leaf_i[2*i], leaf_i[2*i+1]);
    end
    for (int i = 0; i < NSRC/4; i++) begin
      l2_q[i] <= pick(l1_q[2*i], l1_q[2*i+1]);
    end
    for (int i = 0; i < NSRC/8; i++) begin
      l3_q[i] <= pick(l2_q[2*i], l2_q[2*i+1]);
    end
    for (int i = 0; i < NSRC/16; i++) begin
      l4_q[i] <= pick(l3_q[2*i], l3_q[2*i+1]);
    end
    res_q <= pick(l4_q[0], l4_q[1]);
  end

  assign vld_o = vld_q[4];
  assign tag_o = tag_q[4];
  assign id_o  = res_q.vld ? res_q.id : '0;

endmodule

FILE: hw/rtl/pic_datapath.sv
// Register file, address decode, claim/complete and interrupt line datapath.
module pic_datapath import pic_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [1:0]        opcode_i,
  input  logic [OFF_W-1:0]  bus_offset_i,
  input  logic [DATA_W-1:0] write_data_i,
  input  logic [SRC_W-1:0]  source_id_i,
  input  logic              source_level_i,
  output logic [DATA_W-1:0] read_data_o,
  output logic [IRQ_W-1:0]  context_irq_o
);

  logic [1:0]        op_q;
  logic [OFF_W-1:0]  off_q;
  logic [DATA_W-1:0] wdata_q;
  logic [SRC_W-1:0]  sid_q;
  logic              lvl_q;

  logic [NSRC-1:0]   pend_q, pend_d;
  logic [DATA_W-1:0] prio_q [NSRC];
  logic [DATA_W-1:0] en_q [CONTEXTS];
  logic [DATA_W-1:0] thr_q [CONTEXTS];
  logic [SRC_W-1:0]  claim_q [CONTEXTS];
  logic [DATA_W-1:0] rdata_q, rdata_d;
  logic [IRQ_W-1:0]  irq_q;

  // address decode of the latched beat
  logic             prio_hit, prio_ok, pend_hit, en_hit, cx_hit, w0, thr_sel, clm_sel;
  logic [OFF_W-1:0] en_rel, cx_rel;
  logic [CTX_W-1:0] bus_ctx, ctx_sel;
  logic [SRC_W-1:0] src;

  always_comb begin
    en_rel   = off_q - ENAB_BASE;
    cx_rel   = off_q - CTX_REG_BASE;
    prio_hit = off_q < PRIO_END;
    prio_ok  = (off_q[11:7] == '0) && (off_q[6:2] != '0);
    src      = off_q[6:2];
    pend_hit = (off_q >= PEND_BASE) && (off_q < PEND_END);
    en_hit   = (off_q >= ENAB_BASE) && (off_q < ENAB_END);
    cx_hit   = (off_q >= CTX_REG_BASE) && (off_q < CTX_END);
    w0       = off_q[6:2] == '0;
    thr_sel  = cx_rel[11:0] == REG_THRESH;
    clm_sel  = cx_rel[11:0] == REG_CLAIM;
    bus_ctx  = en_hit ? en_rel[7 +: CTX_W] : cx_rel[12 +: CTX_W];
    ctx_sel  = cmd_i.sel_irq ? CTX_W'(cmd_i.irq_ctx) : bus_ctx;
  end

  logic [DATA_W-1:0] en_sel, thr_val;
  logic [SRC_W-1:0]  clm_val;

  assign en_sel  = en_q[ctx_sel];
  assign thr_val = thr_q[ctx_sel];
  assign clm_val = claim_q[ctx_sel];

  // eligibility leaves: pending, enabled and strictly above threshold
  node_t           leaf [NSRC];
  logic [NSRC-1:0] live;

  always_comb begin
    live = pend_q & en_sel & ~NSRC'(1);
    for (int i = 0; i < NSRC; i++) begin
      leaf[i].vld  = live[i] && (prio_q[i] > thr_val);
      leaf[i].prio = prio_q[i];
      leaf[i].id   = SRC_W'(i);
    end
  end

  logic             res_vld;
  tag_t             res_tag, go_tag;
  logic [SRC_W-1:0] res_id;

  assign go_tag.irq = cmd_i.sel_irq;
  assign go_tag.ctx = cmd_i.irq_ctx;

  pic_tree u_tree (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.tree_go),
    .tag_i  (go_tag),
    .leaf_i (leaf),
    .vld_o  (res_vld),
    .tag_o  (res_tag),
    .id_o   (res_id)
  );

  logic do_write, do_cmpl;

  assign do_write = cmd_i.exec && (op_q == OP_WRITE);
  assign do_cmpl  = do_write && cx_hit && clm_sel && (wdata_q != '0)
                    && (wdata_q == {{(DATA_W-SRC_W){1'b0}}, clm_val});

  always_comb begin
    rdata_d = rdata_q;
    pend_d  = pend_q;
    if (cmd_i.exec) begin
      rdata_d = '0;
      case (op_e'(op_q))
        OP_READ: begin
          if (prio_hit) begin
            rdata_d = prio_ok ? prio_q[src] : '0;
          end else if (pend_hit) begin
            rdata_d = w0 ? (pend_q & ~DATA_W'(1)) : '0;
          end else if (en_hit) begin
            rdata_d = w0 ? (en_sel & ~DATA_W'(1)) : '0;
          end else if (cx_hit && thr_sel) begin
            rdata_d = thr_val;
          end
        end
        OP_LEVEL: begin
          if (sid_q != '0) begin
            pend_d[sid_q] = lvl_q;
          end
        end
        default: begin
          rdata_d = '0;
        end
      endcase
    end
    if (cmd_i.claim_apply) begin
      rdata_d = {{(DATA_W-SRC_W){1'b0}}, res_id};
      if (res_id != '0) begin
        pend_d[res_id] = 1'b0;
      end
    end
    pend_d[0] = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= opcode_i;
      off_q   <= bus_offset_i;
      wdata_q <= write_data_i;
      sid_q   <= source_id_i;
      lvl_q   <= source_level_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      rdata_q <= '0;
      irq_q   <= '0;
      for (int i = 0; i < NSRC; i++) begin
        prio_q[i] <= '0;
      end
      for (int c = 0; c < CONTEXTS; c++) begin
        en_q[c]    <= '0;
        thr_q[c]   <= '0;
        claim_q[c] <= '0;
      end
    end else begin
      pend_q  <= pend_d;
      rdata_q <= rdata_d;
      if (do_write && prio_hit && prio_ok) begin
        prio_q[src] <= wdata_q;
      end
      if (do_write && en_hit && w0) begin
        en_q[bus_ctx] <= wdata_q & ~DATA_W'(1);
      end
      if (do_write && cx_hit && thr_sel) begin
        thr_q[bus_ctx] <= wdata_q;
      end
      if (do_cmpl) begin
        claim_q[bus_ctx] <= '0;
      end
      if (cmd_i.claim_apply && (res_id != '0)) begin
        claim_q[bus_ctx] <= res_id;
      end
      // record the line of the context whose pass just left the tree
      if (res_vld && res_tag.irq) begin
        irq_q[res_tag.ctx] <= res_id != '0;
      end
    end
  end

  assign sts_o.is_claim = (op_q == OP_READ) && cx_hit && clm_sel;
  assign sts_o.res_vld  = res_vld;
  assign sts_o.res_irq  = res_tag.irq;
  assign sts_o.res_last = res_tag.ctx == 1'(IRQ_N - 1);

  assign read_data_o   = rdata_q;
  assign context_irq_o = irq_q;

`ifndef SYNTHESIS
  a_pend0_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pend_q[0])
    else $error("pending bit of source zero set");

  a_claim_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.claim_apply && (res_id != '0)) |=> !pend_q[$past(res_id)])
    else $error("claimed source still pending");
`endif

endmodule

FILE: hw/rtl/pic_ctrl.sv
// Sequencer: beat acceptance, claim pass, interrupt line passes, result strobe.
module pic_ctrl import pic_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  output logic strobe,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = sts_i.is_claim ? ST_CLAIM : ST_IRQ0;
      end
      ST_CLAIM: begin
        if (sts_i.res_vld) begin
          state_d = ST_IRQ0;
        end
      end
      ST_IRQ0: begin
        state_d = (IRQ_N > 1) ? ST_IRQ1 : ST_WAIT;
      end
      ST_IRQ1: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts_i.res_vld && sts_i.res_irq && sts_i.res_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy   = 1'b1;
    strobe = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      ST_EXEC: begin
        cmd_o.exec    = 1'b1;
        cmd_o.tree_go = sts_i.is_claim;
      end
      ST_CLAIM: begin
        cmd_o.claim_apply = sts_i.res_vld;
      end
      ST_IRQ0: begin
        cmd_o.tree_go = 1'b1;
        cmd_o.sel_irq = 1'b1;
      end
      ST_IRQ1: begin
        cmd_o.tree_go = 1'b1;
        cmd_o.sel_irq = 1'b1;
        cmd_o.irq_ctx = 1'b1;
      end
      ST_DONE: begin
        strobe = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |=> !strobe && !busy)
    else $error("result beat not followed by idle");

  a_claim_result_place : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts_i.res_vld && !sts_i.res_irq) |-> (state_q == ST_CLAIM))
    else $error("claim pass result outside claim wait");

  a_irq_result_place : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts_i.res_vld && sts_i.res_irq) |-> (state_q == ST_WAIT))
    else $error("line pass result outside line wait");
`endif

endmodule
